// ===== src/assert_macros.svh =====
// Assertion helpers for the calendar converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/escc_pkg.sv =====
package escc_pkg;

	localparam logic [31:0] Epoch2000 = 32'd946684800;
	localparam int unsigned NumStages = 5;

	// Request kinds.
	localparam logic ReqToCal  = 1'b0;
	localparam logic ReqToSecs = 1'b1;

	typedef struct packed {
		logic [31:0] unix_seconds;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
		logic        out_of_range;
	} result_t;

	// Days before the first of each month in a common year.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		case (m)
			4'd1: month_start = 9'd0;
			4'd2: month_start = 9'd31;
			4'd3: month_start = 9'd59;
			4'd4: month_start = 9'd90;
			4'd5: month_start = 9'd120;
			4'd6: month_start = 9'd151;
			4'd7: month_start = 9'd181;
			4'd8: month_start = 9'd212;
			4'd9: month_start = 9'd243;
			4'd10: month_start = 9'd273;
			4'd11: month_start = 9'd304;
			4'd12: month_start = 9'd334;
			default: month_start = 9'd0;
		endcase
	endfunction

endpackage

// ===== src/escc_datapath.sv =====
// Five-stage converter datapath with a stall enable shared by all stages.
module escc_datapath import escc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic        req_type,
	input  logic [31:0] in_unix_seconds,
	input  logic [11:0] in_year,
	input  logic [3:0]  in_month,
	input  logic [4:0]  in_day,
	input  logic [4:0]  in_hour,
	input  logic [5:0]  in_minute,
	input  logic [5:0]  in_second,
	output result_t     res
);

	// ---------------- stage 1: range checks, seconds split
	logic        req_s1, bad_s1;
	logic [31:0] t_s1;
	logic [11:0] yr_s1;
	logic [3:0]  mo_s1;
	logic [4:0]  dy_s1, hr_s1;
	logic [5:0]  mi_s1, se_s1;
	logic [26:0] mins_s1;

	logic [31:0] r0;
	logic [63:0] q60a;
	logic [26:0] mins_c;
	logic        bad_c;
	always_comb begin
		r0 = in_unix_seconds - Epoch2000;
		// floor(r0/60) by reciprocal, exact for 32-bit r0
		q60a = {32'd0, r0} * 64'd2290649225;
		mins_c = q60a[63:37];
		if (req_type == ReqToCal) begin
			bad_c = in_unix_seconds < Epoch2000;
		end else begin
			bad_c = (in_year < 12'd2000) || (in_year > 12'd2105) || (in_month == 4'd0)
				|| (in_month > 4'd12) || (in_day == 5'd0) || (in_hour > 5'd23)
				|| (in_minute > 6'd59) || (in_second > 6'd59);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= req_type;
			bad_s1 <= bad_c;
			t_s1 <= in_unix_seconds;
			yr_s1 <= in_year;
			mo_s1 <= in_month;
			dy_s1 <= in_day;
			hr_s1 <= in_hour;
			mi_s1 <= in_minute;
			se_s1 <= in_second;
			mins_s1 <= mins_c;
		end
	end

	// ---------------- stage 2: hours / minutes; calendar day number
	logic        req_s2, bad_s2;
	logic [31:0] t_s2;
	logic [11:0] yr_s2;
	logic [3:0]  mo_s2;
	logic [4:0]  dy_s2, hr_s2;
	logic [5:0]  mi_s2, se_s2;
	logic [20:0] hrs_s2;
	logic [15:0] dn_s2;

	logic [58:0] q60b;
	logic [20:0] hrs_c;
	logic [5:0]  secd_c, mind_c;
	logic [6:0]  yo;
	logic [15:0] dn_c;
	always_comb begin
		q60b = {32'd0, mins_s1} * 59'd2290649225;
		hrs_c = q60b[57:37];
		secd_c = 6'(t_s1 - Epoch2000 - 32'(mins_s1) * 32'd60);
		mind_c = 6'(mins_s1 - 27'(hrs_c) * 27'd60);
		yo = 7'(yr_s1 - 12'd2000);
		dn_c = 16'(yo) * 16'd365 + 16'((yo + 7'd3) >> 2) + 16'(month_start(mo_s1))
			+ 16'(dy_s1) - 16'd1 + ((mo_s1 > 4'd2 && yo[1:0] == 2'd0) ? 16'd1 : 16'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2 <= req_s1;
			bad_s2 <= bad_s1;
			t_s2 <= t_s1;
			yr_s2 <= yr_s1;
			mo_s2 <= mo_s1;
			dy_s2 <= dy_s1;
			hrs_s2 <= hrs_c;
			dn_s2 <= dn_c;
			if (req_s1 == ReqToCal) begin
				se_s2 <= secd_c;
				mi_s2 <= mind_c;
			end else begin
				se_s2 <= se_s1;
				mi_s2 <= mi_s1;
			end
			hr_s2 <= hr_s1;
		end
	end

	// ---------------- stage 3: days and hour
	logic        req_s3, bad_s3;
	logic [31:0] t_s3;
	logic [11:0] yr_s3;
	logic [3:0]  mo_s3;
	logic [4:0]  dy_s3, hr_s3;
	logic [5:0]  mi_s3, se_s3;
	logic [15:0] days_s3;

	logic [34:0] q24;
	logic [15:0] days_c;
	logic [4:0]  hrd_c;
	always_comb begin
		// floor(h/24) = floor(h/8 /3)
		q24 = {17'd0, hrs_s2[20:3]} * 35'd174763;
		days_c = q24[34:19];
		hrd_c = 5'(hrs_s2 - 21'(days_c) * 21'd24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s3 <= req_s2;
			bad_s3 <= bad_s2;
			t_s3 <= t_s2;
			mi_s3 <= mi_s2;
			se_s3 <= se_s2;
			yr_s3 <= yr_s2;
			mo_s3 <= mo_s2;
			dy_s3 <= dy_s2;
			if (req_s2 == ReqToCal) begin
				days_s3 <= days_c;
				hr_s3 <= hrd_c;
			end else begin
				days_s3 <= dn_s2;
				hr_s3 <= hr_s2;
			end
		end
	end

	// ---------------- stage 4: year and day of year; seconds product
	logic        req_s4, bad_s4;
	logic [31:0] t_s4;
	logic [11:0] yr_s4;
	logic [3:0]  mo_s4;
	logic [4:0]  dy_s4, hr_s4;
	logic [5:0]  mi_s4, se_s4;
	logic [15:0] days_s4;
	logic [8:0]  doy_s4;
	logic        leap_s4;

	logic [31:0] q1461;
	logic [5:0]  cyc;
	logic [10:0] rem;
	logic [1:0]  yin;
	logic [8:0]  doy_c;
	always_comb begin
		q1461 = {16'd0, days_s3} * 32'd45934;
		cyc = 6'(q1461 >> 26);
		rem = 11'(days_s3 - 16'(cyc) * 16'd1461);
		if (rem < 11'd366) begin
			yin = 2'd0; doy_c = 9'(rem);
		end else if (rem < 11'd731) begin
			yin = 2'd1; doy_c = 9'(rem - 11'd366);
		end else if (rem < 11'd1096) begin
			yin = 2'd2; doy_c = 9'(rem - 11'd731);
		end else begin
			yin = 2'd3; doy_c = 9'(rem - 11'd1096);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s4 <= req_s3;
			bad_s4 <= bad_s3;
			hr_s4 <= hr_s3;
			mi_s4 <= mi_s3;
			se_s4 <= se_s3;
			days_s4 <= days_s3;
			doy_s4 <= doy_c;
			leap_s4 <= (yin == 2'd0);
			if (req_s3 == ReqToCal) begin
				t_s4 <= t_s3;
				yr_s4 <= 12'd2000 + {4'd0, cyc, 2'b00} + 12'(yin);
			end else begin
				t_s4 <= 32'(days_s3) * 32'd86400 + Epoch2000;
				yr_s4 <= yr_s3;
			end
			mo_s4 <= mo_s3;
			dy_s4 <= dy_s3;
		end
	end

	// ---------------- stage 5: month, weekday, final assembly
	logic [3:0]  mo_c;
	logic [4:0]  dd_c;
	logic [8:0]  ms;
	logic [2:0]  wd_c;
	logic [16:0] wsum;
	logic [31:0] q7;
	logic [31:0] tsec_c;
	always_comb begin
		mo_c = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			ms = month_start(4'(m)) + ((leap_s4 && m > 2) ? 9'd1 : 9'd0);
			if (doy_s4 >= ms) mo_c = 4'(m);
		end
		ms = month_start(mo_c) + ((leap_s4 && mo_c > 4'd2) ? 9'd1 : 9'd0);
		dd_c = 5'(doy_s4 - ms + 9'd1);
		wsum = 17'(days_s4) + 17'd6;
		q7 = {15'd0, wsum} * 32'd18725;
		wd_c = 3'(wsum - 17'(q7 >> 17) * 17'd7);
		tsec_c = t_s4 + 32'(hr_s4) * 32'd3600 + 32'(mi_s4) * 32'd60 + 32'(se_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (bad_s4) begin
				res <= '{out_of_range: 1'b1, default: '0};
			end else begin
				res.out_of_range <= 1'b0;
				res.hour <= hr_s4;
				res.minute <= mi_s4;
				res.second <= se_s4;
				res.year <= yr_s4;
				res.weekday <= wd_c;
				if (req_s4 == ReqToCal) begin
					res.unix_seconds <= t_s4;
					res.month <= mo_c;
					res.day <= dd_c;
				end else begin
					res.unix_seconds <= tsec_c;
					res.month <= mo_s4;
					res.day <= dy_s4;
				end
			end
		end
	end

endmodule

// ===== src/epoch_seconds_calendar_converter_core.sv =====
// Throughput: one transaction per cycle; a stalled output freezes all five stages.
// Reset: arst_n clears the stage valid bits asynchronously; data is not reset.
// Each stage holds one reciprocal multiply or a short add/compare chain.
`include "assert_macros.svh"
module epoch_seconds_calendar_converter_core import escc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// in_unix_seconds[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
	// in_hour[57:53], in_minute[63:58], in_second[69:64], zero pad to 72
	input  logic [71:0] s_axis_tdata,
	// req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_unix_seconds[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
	// out_hour[57:53], out_minute[63:58], out_second[69:64], weekday[72:70],
	// out_of_range[73], zero pad to 80
	output logic [79:0] m_axis_tdata
);

	logic [NumStages-1:0] vld_q;
	logic                 en;
	result_t              res;

	assign en = m_axis_tready || !vld_q[NumStages-1];
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NumStages-1];

	// Valid bits ride with the stage enables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
		end
	end

	escc_datapath u_dp (
		.clk            (clk),
		.en             (en),
		.req_type       (s_axis_tuser),
		.in_unix_seconds(s_axis_tdata[31:0]),
		.in_year        (s_axis_tdata[43:32]),
		.in_month       (s_axis_tdata[47:44]),
		.in_day         (s_axis_tdata[52:48]),
		.in_hour        (s_axis_tdata[57:53]),
		.in_minute      (s_axis_tdata[63:58]),
		.in_second      (s_axis_tdata[69:64]),
		.res            (res)
	);

	assign m_axis_tdata = {6'd0, res.out_of_range, res.weekday, res.second, res.minute,
		res.hour, res.day, res.month, res.year, res.unix_seconds};

	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`ASSERT_IMPL(a_flag_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[73], m_axis_tdata[72:0] == 73'd0, "flagged result not zero")
	`ASSERT_IMPL(a_wday, clk, arst_n, m_axis_tvalid, m_axis_tdata[72:70] != 3'd7, "weekday out of range")

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import escc_pkg::*;

	// Field order matches the master tdata layout, lowest field last
	typedef struct packed {
		logic        oor;
		logic [2:0]  weekday;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [31:0] secs;
	} cal_result_t;

	// Expected conversion results, oldest first
	class conversion_scoreboard;
		cal_result_t pending[$];
		int mismatches;

		static function bit is_leap(int unsigned y);
			return (y % 4) == 0;
		endfunction

		static function int unsigned days_before_month(int unsigned m);
			int unsigned tbl[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
			return tbl[(m - 1) % 12];
		endfunction

		static function cal_result_t convert(logic req, logic [71:0] d);
			cal_result_t r;
			int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			int unsigned t, rem, days, total, y, m, ml, yl;
			int unsigned yr, mo, dy, hr, mi, se;
			longint unsigned acc;
			r = '0;
			if (req == ReqToCal) begin
				t = d[31:0];
				if (t < Epoch2000) begin
					r.oor = 1'b1;
				end else begin
					rem = t - Epoch2000;
					r.second = 6'(rem % 60); rem /= 60;
					r.minute = 6'(rem % 60); rem /= 60;
					r.hour = 5'(rem % 24);
					days = rem / 24;
					total = days;
					y = 2000;
					forever begin
						yl = is_leap(y) ? 366 : 365;
						if (days < yl) break;
						days -= yl;
						y++;
					end
					m = 1;
					forever begin
						ml = mlen[m - 1] + ((is_leap(y) && m == 2) ? 1 : 0);
						if (days < ml || m >= 12) break;
						days -= ml;
						m++;
					end
					r.secs = t;
					r.year = 12'(y);
					r.month = 4'(m);
					r.day = 5'(days + 1);
					r.weekday = 3'((total + 6) % 7);
				end
			end else begin
				yr = d[43:32]; mo = d[47:44]; dy = d[52:48];
				hr = d[57:53]; mi = d[63:58]; se = d[69:64];
				if (yr < 2000 || yr > 2105 || mo < 1 || mo > 12 || dy < 1 ||
						hr > 23 || mi > 59 || se > 59) begin
					r.oor = 1'b1;
				end else begin
					y = yr - 2000;
					days = dy + days_before_month(mo) + ((mo > 2 && is_leap(y)) ? 1 : 0);
					days = days + 365 * y + (y + 3) / 4 - 1;
					acc = ((longint'(days) * 24 + hr) * 60 + mi) * 60 + se + Epoch2000;
					r.secs = acc[31:0];
					r.year = 12'(yr); r.month = 4'(mo); r.day = 5'(dy);
					r.hour = 5'(hr); r.minute = 6'(mi); r.second = 6'(se);
					r.weekday = 3'((days + 6) % 7);
				end
			end
			return r;
		endfunction

		function void note_request(logic req, logic [71:0] d);
			pending.push_back(convert(req, d));
		endfunction

		function void check_result(logic [79:0] got_bits);
			cal_result_t got, want;
			got = got_bits[73:0];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got_bits);
				return;
			end
			want = pending.pop_front();
			if (got !== want || got_bits[79:74] !== 6'd0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p actual %p pad %b", want, got, got_bits[79:74]);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [79:0] m_axis_tdata;

	conversion_scoreboard sb;
	bit sending_done;
	bit hold_sink;
	int idle_cycles = 0;

	epoch_seconds_calendar_converter_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pack calendar fields into tdata
	function automatic logic [71:0] cal_word(int unsigned y, m, d, h, mi, s);
		logic [71:0] w;
		w = '0;
		w[43:32] = 12'(y); w[47:44] = 4'(m); w[52:48] = 5'(d);
		w[57:53] = 5'(h); w[63:58] = 6'(mi); w[69:64] = 6'(s);
		return w;
	endfunction

	// One input transaction, with a random idle gap before it; valid stays up after it
	task automatic send_request(logic req, logic [71:0] d);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
		if ($urandom_range(0, 1)) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(req, d);
	endtask

	task automatic send_random;
		int unsigned k;
		logic [71:0] d;
		k = $urandom_range(0, 9);
		d = 72'({$urandom(), $urandom(), $urandom()});
		d[71:70] = 2'b00;
		if (k < 4) begin
			d[31:0] = (k == 0) ? $urandom() : Epoch2000 + $urandom_range(0, 32'hFFFFFFFF - Epoch2000);
			send_request(ReqToCal, d);
		end else if (k < 8) begin
			d = cal_word($urandom_range(2000, 2105), $urandom_range(1, 12), $urandom_range(1, 31),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
			send_request(ReqToSecs, d);
		end else begin
			// unconstrained calendar fields, mostly out of range
			send_request(ReqToSecs, d);
		end
	endtask

	// Stimulus
	initial begin
		sb = new();
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= 1'b0;
		s_axis_tdata <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: seconds extremes and boundaries
		send_request(ReqToCal, 72'd0);
		send_request(ReqToCal, 72'd946684799);
		send_request(ReqToCal, 72'd946684800);
		send_request(ReqToCal, 72'd951782400);
		send_request(ReqToCal, 72'd4107542400);
		send_request(ReqToCal, 72'hFFFFFFFF);
		send_request(ReqToCal, {40'hFF_FFFF_FFFF, 32'd1000000000});
		// directed: calendar fields
		send_request(ReqToSecs, cal_word(2000, 1, 1, 0, 0, 0));
		send_request(ReqToSecs, cal_word(2105, 12, 31, 23, 59, 59));
		send_request(ReqToSecs, cal_word(2100, 2, 29, 12, 0, 0));
		send_request(ReqToSecs, cal_word(2001, 2, 30, 1, 2, 3));
		send_request(ReqToSecs, cal_word(1999, 6, 6, 6, 6, 6));
		send_request(ReqToSecs, cal_word(2106, 1, 1, 0, 0, 0));
		send_request(ReqToSecs, cal_word(4095, 15, 31, 31, 63, 63));
		send_request(ReqToSecs, cal_word(2020, 0, 5, 0, 0, 0));
		send_request(ReqToSecs, cal_word(2020, 13, 5, 0, 0, 0));
		send_request(ReqToSecs, cal_word(2020, 5, 0, 0, 0, 0));
		send_request(ReqToSecs, cal_word(2020, 5, 5, 24, 0, 0));
		send_request(ReqToSecs, cal_word(2020, 5, 5, 0, 60, 0));
		send_request(ReqToSecs, cal_word(2020, 5, 5, 0, 0, 60));
		send_request(ReqToSecs, cal_word(0, 0, 0, 0, 0, 0));
		// pause until drained
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		// long sink hold-off while offering a burst
		hold_sink = 1'b1;
		repeat (30) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tuser <= ReqToCal;
			s_axis_tdata <= {40'd0, $urandom()};
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			sb.note_request(s_axis_tuser, s_axis_tdata);
		end
		repeat (430) send_random();
		s_axis_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// Sink: random stalls, plus one long hold-off in its own count
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
			if (hold_sink && !held) begin
				held = 1'b1;
				gap = 60;
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Result checking
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= 2000) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// End of run
	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/escc_pkg.sv
src/escc_datapath.sv
src/epoch_seconds_calendar_converter_core.sv
tb/tb.sv
